// File: src/tpcpwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcpwm_pkg
// Shared widths, request codes, register indexes and scaling constants for
// the three-phase center-aligned PWM generator.
// ----------------------------------------------------------------------------
package tpcpwm_pkg;

  localparam int REQ_W   = 3;
  localparam int DUTY_W  = 16;
  localparam int CNT_W   = 16;
  localparam int DEAD_W  = 7;
  localparam int GATE_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int PHASES_DEFAULT = 3;
  // Number of phases that have a duty field in the input transaction.
  localparam int DUTY_FIELDS = 3;

  localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_RAW     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PERMILLE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ENABLE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DISABLE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TOP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_CMP   = 2'd2;

  localparam logic [CNT_W-1:0] PERIOD_TOP_RESET = 16'd3599;

  // Permille scaling: the product pm * (top + 1) is below 2^26; the quotient
  // by 1000 is taken as a multiply by a rounded-up reciprocal.
  localparam int PM_W    = 10;
  localparam int PROD_W  = 26;
  localparam int QUO_W   = 17;
  localparam logic [PM_W-1:0] PERMILLE_FULL = 10'd1000;
  localparam int DIV_SHIFT = 36;
  localparam int RECIP_W   = 27;
  localparam longint unsigned DIV_MUL =
      ((64'd1 << DIV_SHIFT) + 64'd999) / 64'd1000;

endpackage

// File: src/tpcpwm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpcpwm_if
// Valid/ready channels of the PWM generator: request input, result output
// and register write port.
// ----------------------------------------------------------------------------
interface tpcpwm_in_if;
  logic                              valid;
  logic                              ready;
  logic [tpcpwm_pkg::REQ_W-1:0]      req_type;
  logic [tpcpwm_pkg::DUTY_W-1:0]     duty_a;
  logic [tpcpwm_pkg::DUTY_W-1:0]     duty_b;
  logic [tpcpwm_pkg::DUTY_W-1:0]     duty_c;

  modport source (output valid, req_type, duty_a, duty_b, duty_c, input ready);
  modport sink   (input valid, req_type, duty_a, duty_b, duty_c, output ready);
endinterface

interface tpcpwm_out_if;
  logic                              valid;
  logic                              ready;
  logic [tpcpwm_pkg::GATE_W-1:0]     high_side;
  logic [tpcpwm_pkg::GATE_W-1:0]     low_side;
  logic                              drive_enable;
  logic                              adc_trigger;
  logic [tpcpwm_pkg::CNT_W-1:0]      counter_value;
  logic                              update_event;

  modport source (output valid, high_side, low_side, drive_enable, adc_trigger,
                  counter_value, update_event, input ready);
  modport sink   (input valid, high_side, low_side, drive_enable, adc_trigger,
                  counter_value, update_event, output ready);
endinterface

interface tpcpwm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tpcpwm_pkg::CFG_IDX_W-1:0]  index;
  logic [tpcpwm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/three_phase_center_pwm_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_phase_center_pwm_top
// Center-aligned complementary PWM with dead time, preloaded compares and an
// ADC trigger compare, advanced by one tick transaction per timer clock.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  in_ch    sink       req_type, duty_a, duty_b, duty_c
//  out_ch   source     high_side, low_side, drive_enable, adc_trigger,
//                      counter_value, update_event
//  cfg_ch   sink       index, data (period_top, dead_ticks, trigger_compare)
//
// One transaction per cycle while in_ch.ready is high; its result is registered
// and appears in the next cycle. The result register keeps taking transactions
// while out_ch.ready is high, so a held result stalls only the input side. The
// longest path is the permille reciprocal multiply feeding the compare load.
// Synchronous active-low reset; register writes are always accepted.
module three_phase_center_pwm_top #(
  parameter int PHASES = tpcpwm_pkg::PHASES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  tpcpwm_in_if.sink           in_ch,
  tpcpwm_out_if.source        out_ch,
  tpcpwm_cfg_if.sink          cfg_ch
);

  localparam int CW = tpcpwm_pkg::CNT_W;
  localparam int DW = tpcpwm_pkg::DEAD_W;

  logic [CW-1:0] period_top_r;
  logic [DW-1:0] dead_ticks_r;
  logic [CW-1:0] trig_cmp_r;

  logic [CW-1:0] count_r, count_nxt;
  logic          down_r, down_nxt;
  logic          on_r, on_nxt;
  logic          uev;

  logic          accept;
  logic          tick;
  logic          is_raw;
  logic          is_pm;

  logic [CW-1:0]                   act_r     [PHASES];
  logic [tpcpwm_pkg::PROD_W-1:0]   pre_val_r [PHASES];
  logic                            pre_pm_r  [PHASES];
  logic                            last_r    [PHASES];
  logic [DW-1:0]                   dc_r      [PHASES];
  logic [PHASES-1:0]               hi_nxt;
  logic [PHASES-1:0]               lo_nxt;

  logic                            out_valid_r;
  logic [tpcpwm_pkg::GATE_W-1:0]   high_r, low_r;
  logic                            drive_r, adc_r, uev_r;
  logic [CW-1:0]                   cnt_out_r;
  logic [tpcpwm_pkg::GATE_W-1:0]   hi_gate, lo_gate;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign accept = in_ch.valid && in_ch.ready;
  assign tick   = accept && (in_ch.req_type == tpcpwm_pkg::REQ_TICK);
  assign is_raw = accept && (in_ch.req_type == tpcpwm_pkg::REQ_RAW);
  assign is_pm  = accept && (in_ch.req_type == tpcpwm_pkg::REQ_PERMILLE);

  // Up/down counter; a count above top after a top write turns down at once.
  always_comb begin
    count_nxt = count_r;
    down_nxt  = down_r;
    if (tick) begin
      if (!down_r) begin
        if (count_r < period_top_r) begin
          count_nxt = count_r + 16'd1;
        end else begin
          down_nxt = 1'b1;
          if (count_r != '0) count_nxt = count_r - 16'd1;
        end
      end else begin
        if (count_r != '0) begin
          count_nxt = count_r - 16'd1;
        end else begin
          down_nxt = 1'b0;
          if (count_r < period_top_r) count_nxt = count_r + 16'd1;
        end
      end
    end
  end

  assign uev = tick && ((count_nxt == period_top_r) || (count_nxt == '0));

  always_comb begin
    on_nxt = on_r;
    if (accept && (in_ch.req_type == tpcpwm_pkg::REQ_ENABLE)) on_nxt = 1'b1;
    if (accept && (in_ch.req_type == tpcpwm_pkg::REQ_DISABLE)) on_nxt = 1'b0;
  end

  for (genvar i = 0; i < PHASES; i++) begin : g_phase
    logic [tpcpwm_pkg::DUTY_W-1:0] duty_in;
    logic [tpcpwm_pkg::PM_W-1:0]   pm_clamp;
    logic [tpcpwm_pkg::PROD_W:0]   prod_full;
    logic [CW:0]                   top_plus;
    logic [tpcpwm_pkg::PROD_W+tpcpwm_pkg::RECIP_W-1:0] recip;
    logic [tpcpwm_pkg::QUO_W-1:0]  quo;
    logic [CW-1:0]                 pre_eff;
    logic [CW-1:0]                 act_nxt;
    logic                          ref_nxt;
    logic                          last_nxt;
    logic [DW-1:0]                 dc_nxt;

    if (i == 0) begin : g_a
      assign duty_in = in_ch.duty_a;
    end else if (i == 1) begin : g_b
      assign duty_in = in_ch.duty_b;
    end else if (i == 2) begin : g_c
      assign duty_in = in_ch.duty_c;
    end else begin : g_none
      assign duty_in = '0;
    end

    // First half of the permille scaling: clamp and multiply by top + 1.
    assign pm_clamp = (duty_in > 16'(tpcpwm_pkg::PERMILLE_FULL)) ?
                      tpcpwm_pkg::PERMILLE_FULL : duty_in[tpcpwm_pkg::PM_W-1:0];
    assign top_plus  = {1'b0, period_top_r} + 17'd1;
    assign prod_full = (tpcpwm_pkg::PROD_W+1)'(pm_clamp) *
                       (tpcpwm_pkg::PROD_W+1)'(top_plus);

    // Second half, on the stored product: divide by 1000 and saturate.
    assign recip = (tpcpwm_pkg::PROD_W+tpcpwm_pkg::RECIP_W)'(pre_val_r[i]) *
                   (tpcpwm_pkg::PROD_W+tpcpwm_pkg::RECIP_W)'(tpcpwm_pkg::DIV_MUL);
    assign quo = recip[tpcpwm_pkg::DIV_SHIFT +: tpcpwm_pkg::QUO_W];

    always_comb begin
      if (!pre_pm_r[i]) begin
        pre_eff = pre_val_r[i][CW-1:0];
      end else if (quo[tpcpwm_pkg::QUO_W-1]) begin
        pre_eff = '1;
      end else begin
        pre_eff = quo[CW-1:0];
      end
    end

    assign act_nxt = uev ? pre_eff : act_r[i];
    assign ref_nxt = count_nxt < act_nxt;

    always_comb begin
      last_nxt = last_r[i];
      dc_nxt   = dc_r[i];
      if (tick) begin
        last_nxt = ref_nxt;
        if (ref_nxt != last_r[i]) begin
          dc_nxt = dead_ticks_r;
        end else if (dc_r[i] != '0) begin
          dc_nxt = dc_r[i] - 7'd1;
        end
      end
    end

    assign hi_nxt[i] = on_nxt && (dc_nxt == '0) && last_nxt;
    assign lo_nxt[i] = on_nxt && (dc_nxt == '0) && !last_nxt;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        act_r[i]     <= '0;
        pre_val_r[i] <= '0;
        pre_pm_r[i]  <= 1'b0;
        last_r[i]    <= 1'b0;
        dc_r[i]      <= '0;
      end else begin
        act_r[i]  <= act_nxt;
        last_r[i] <= last_nxt;
        dc_r[i]   <= dc_nxt;
        if (is_raw) begin
          pre_val_r[i] <= tpcpwm_pkg::PROD_W'(duty_in);
          pre_pm_r[i]  <= 1'b0;
        end else if (is_pm) begin
          pre_val_r[i] <= prod_full[tpcpwm_pkg::PROD_W-1:0];
          pre_pm_r[i]  <= 1'b1;
        end
      end
    end
  end

  // Phases past the third have no gate bits in the result.
  for (genvar j = 0; j < tpcpwm_pkg::GATE_W; j++) begin : g_gate
    if (j < PHASES) begin : g_used
      assign hi_gate[j] = hi_nxt[j];
      assign lo_gate[j] = lo_nxt[j];
    end else begin : g_unused
      assign hi_gate[j] = 1'b0;
      assign lo_gate[j] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_top_r <= tpcpwm_pkg::PERIOD_TOP_RESET;
      dead_ticks_r <= '0;
      trig_cmp_r   <= '0;
      count_r      <= '0;
      down_r       <= 1'b0;
      on_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      down_r  <= down_nxt;
      on_r    <= on_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          tpcpwm_pkg::CFG_PERIOD_TOP: period_top_r <= cfg_ch.data;
          tpcpwm_pkg::CFG_DEAD_TICKS: dead_ticks_r <= cfg_ch.data[DW-1:0];
          tpcpwm_pkg::CFG_TRIG_CMP:   trig_cmp_r   <= cfg_ch.data;
          default: ;
        endcase
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      high_r    <= hi_gate;
      low_r     <= lo_gate;
      drive_r   <= on_nxt;
      adc_r     <= count_nxt >= trig_cmp_r;
      cnt_out_r <= count_nxt;
      uev_r     <= uev;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.high_side     = high_r;
  assign out_ch.low_side      = low_r;
  assign out_ch.drive_enable  = drive_r;
  assign out_ch.adc_trigger   = adc_r;
  assign out_ch.counter_value = cnt_out_r;
  assign out_ch.update_event  = uev_r;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-phase center-aligned PWM generator. A
// cycle-level predictor tracks the counter, the preloaded compares, the
// dead-time counters and the output enable. Every accepted request yields one
// expected gate result, which is compared field by field with the block's
// output. Directed tests cover the extremes and corner cases. Random traffic
// then runs under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [tpcpwm_pkg::REQ_W-1:0] REQ_FIRST_UNUSED = 3'd5;
  localparam logic [tpcpwm_pkg::REQ_W-1:0] REQ_LAST_UNUSED  = 3'd7;

  typedef struct packed {
    logic [tpcpwm_pkg::REQ_W-1:0]        req;
    logic [2:0][tpcpwm_pkg::DUTY_W-1:0]  duty;
  } pwm_req_t;

  typedef struct packed {
    logic [tpcpwm_pkg::GATE_W-1:0] high_side;
    logic [tpcpwm_pkg::GATE_W-1:0] low_side;
    logic                          drive_enable;
    logic                          adc_trigger;
    logic [tpcpwm_pkg::CNT_W-1:0]  counter_value;
    logic                          update_event;
  } gate_result_t;

  logic clk = 1'b0;
  logic rst_n;

  tpcpwm_in_if  in_ch();
  tpcpwm_out_if out_ch();
  tpcpwm_cfg_if cfg_ch();

  three_phase_center_pwm_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  // Predictor state and register copies.
  logic [tpcpwm_pkg::CNT_W-1:0]  top_reg;
  logic [tpcpwm_pkg::DEAD_W-1:0] dead_reg;
  logic [tpcpwm_pkg::CNT_W-1:0]  trig_reg;
  logic [tpcpwm_pkg::CNT_W-1:0]  pwm_cnt;
  logic                          pwm_down;
  logic [tpcpwm_pkg::CNT_W-1:0]  cmp_active  [3];
  logic [tpcpwm_pkg::CNT_W-1:0]  cmp_preload [3];
  logic                          gates_on;
  logic                          ref_last    [3];
  logic [tpcpwm_pkg::DEAD_W-1:0] dead_left   [3];

  gate_result_t gate_expect_q [$];

  int src_idle_pct = 23;
  int snk_idle_pct = 60;
  int stall_cycles = 0;
  int n_errors     = 0;
  int n_items      = 0;
  int n_results    = 0;
  int n_updates    = 0;
  int n_reg_writes = 0;

  function automatic void model_reset();
    top_reg  = tpcpwm_pkg::PERIOD_TOP_RESET;
    dead_reg = '0;
    trig_reg = '0;
    pwm_cnt  = '0;
    pwm_down = 1'b0;
    gates_on = 1'b0;
    for (int i = 0; i < 3; i++) begin
      cmp_active[i]  = '0;
      cmp_preload[i] = '0;
      ref_last[i]    = 1'b0;
      dead_left[i]   = '0;
    end
  endfunction

  function automatic void model_write_reg(logic [tpcpwm_pkg::CFG_IDX_W-1:0] idx,
                                          logic [tpcpwm_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      tpcpwm_pkg::CFG_PERIOD_TOP: top_reg  = data;
      tpcpwm_pkg::CFG_DEAD_TICKS: dead_reg = data[tpcpwm_pkg::DEAD_W-1:0];
      tpcpwm_pkg::CFG_TRIG_CMP:   trig_reg = data;
      default: ;
    endcase
  endfunction

  // Clamp to full scale, scale by (top + 1) / 1000 and saturate to 16 bits.
  function automatic logic [tpcpwm_pkg::CNT_W-1:0] permille_cmp(
      logic [tpcpwm_pkg::DUTY_W-1:0] pm);
    longint unsigned p;
    longint unsigned s;
    p = 64'(pm);
    if (p > 64'(tpcpwm_pkg::PERMILLE_FULL)) p = 64'(tpcpwm_pkg::PERMILLE_FULL);
    s = (p * (64'(top_reg) + 64'd1)) / 64'(tpcpwm_pkg::PERMILLE_FULL);
    if (s > 64'hFFFF) s = 64'hFFFF;
    return s[tpcpwm_pkg::CNT_W-1:0];
  endfunction

  function automatic gate_result_t pwm_step(pwm_req_t r);
    gate_result_t res;
    logic         refl;
    res = '0;
    case (r.req)
      tpcpwm_pkg::REQ_TICK: begin
        if (!pwm_down) begin
          if (pwm_cnt < top_reg) begin
            pwm_cnt++;
          end else begin
            // Also covers a counter left above a freshly lowered top.
            pwm_down = 1'b1;
            if (pwm_cnt != 0) pwm_cnt--;
          end
        end else begin
          if (pwm_cnt != 0) begin
            pwm_cnt--;
          end else begin
            pwm_down = 1'b0;
            if (pwm_cnt < top_reg) pwm_cnt++;
          end
        end
        res.update_event = (pwm_cnt == top_reg) || (pwm_cnt == 0);
        if (res.update_event) begin
          for (int i = 0; i < 3; i++) cmp_active[i] = cmp_preload[i];
        end
        for (int i = 0; i < 3; i++) begin
          refl = pwm_cnt < cmp_active[i];
          if (refl != ref_last[i]) begin
            dead_left[i] = dead_reg;
          end else if (dead_left[i] != 0) begin
            dead_left[i]--;
          end
          ref_last[i] = refl;
        end
      end
      tpcpwm_pkg::REQ_RAW: begin
        for (int i = 0; i < 3; i++) cmp_preload[i] = r.duty[i];
      end
      tpcpwm_pkg::REQ_PERMILLE: begin
        for (int i = 0; i < 3; i++) cmp_preload[i] = permille_cmp(r.duty[i]);
      end
      tpcpwm_pkg::REQ_ENABLE:  gates_on = 1'b1;
      tpcpwm_pkg::REQ_DISABLE: gates_on = 1'b0;
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      if (gates_on && dead_left[i] == 0) begin
        if (ref_last[i]) res.high_side[i] = 1'b1;
        else res.low_side[i] = 1'b1;
      end
    end
    res.drive_enable  = gates_on;
    res.adc_trigger   = pwm_cnt >= trig_reg;
    res.counter_value = pwm_cnt;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_errors++;
    end
  endfunction

  // Monitor: register writes and requests update the predictor, results are
  // compared with the oldest expectation. All sampled at the clock edge.
  always @(posedge clk) begin
    pwm_req_t     req;
    gate_result_t exp_r;
    gate_result_t got_r;
    if (!rst_n) begin
      model_reset();
      gate_expect_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        model_write_reg(cfg_ch.index, cfg_ch.data);
        n_reg_writes++;
      end
      if (in_ch.valid && in_ch.ready) begin
        req.req     = in_ch.req_type;
        req.duty[0] = in_ch.duty_a;
        req.duty[1] = in_ch.duty_b;
        req.duty[2] = in_ch.duty_c;
        gate_expect_q.push_back(pwm_step(req));
        n_items++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got_r.high_side     = out_ch.high_side;
        got_r.low_side      = out_ch.low_side;
        got_r.drive_enable  = out_ch.drive_enable;
        got_r.adc_trigger   = out_ch.adc_trigger;
        got_r.counter_value = out_ch.counter_value;
        got_r.update_event  = out_ch.update_event;
        if (gate_expect_q.size() == 0) begin
          $error("result transaction with no request outstanding");
          n_errors++;
        end else begin
          exp_r = gate_expect_q.pop_front();
          check_field("high_side", 32'(exp_r.high_side), 32'(got_r.high_side));
          check_field("low_side", 32'(exp_r.low_side), 32'(got_r.low_side));
          check_field("drive_enable", 32'(exp_r.drive_enable),
                      32'(got_r.drive_enable));
          check_field("adc_trigger", 32'(exp_r.adc_trigger),
                      32'(got_r.adc_trigger));
          check_field("counter_value", 32'(exp_r.counter_value),
                      32'(got_r.counter_value));
          check_field("update_event", 32'(exp_r.update_event),
                      32'(got_r.update_event));
          n_results++;
          if (exp_r.update_event) n_updates++;
        end
      end
    end
  end

  // Result side: random back-pressure, or a forced stall when requested.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_cycles > 0) begin
        out_ch.ready <= 1'b0;
        stall_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic send_req(logic [tpcpwm_pkg::REQ_W-1:0] req,
                          logic [tpcpwm_pkg::DUTY_W-1:0] a,
                          logic [tpcpwm_pkg::DUTY_W-1:0] b,
                          logic [tpcpwm_pkg::DUTY_W-1:0] c);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.duty_a   <= a;
    in_ch.duty_b   <= b;
    in_ch.duty_c   <= c;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_req(tpcpwm_pkg::REQ_TICK, 16'($urandom), 16'($urandom),
                        16'($urandom));
  endtask

  task automatic wait_results();
    in_ch.valid <= 1'b0;
    // The monitor takes the last accepted request at this edge, so the queue
    // is looked at only from the next edge on.
    @(posedge clk);
    while (gate_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_config(logic [tpcpwm_pkg::CNT_W-1:0] top,
                              logic [tpcpwm_pkg::DEAD_W-1:0] dead,
                              logic [tpcpwm_pkg::CNT_W-1:0] trig);
    logic [tpcpwm_pkg::CFG_IDX_W-1:0]  idx  [3];
    logic [tpcpwm_pkg::CFG_DATA_W-1:0] data [3];
    idx[0] = tpcpwm_pkg::CFG_PERIOD_TOP;
    idx[1] = tpcpwm_pkg::CFG_DEAD_TICKS;
    idx[2] = tpcpwm_pkg::CFG_TRIG_CMP;
    data[0] = top;
    data[1] = {{(tpcpwm_pkg::CFG_DATA_W-tpcpwm_pkg::DEAD_W){1'b0}}, dead};
    data[2] = trig;
    wait_results();
    repeat (4) @(posedge clk);
    for (int i = 0; i < 3; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= data[i];
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic pwm_req_t rand_req();
    pwm_req_t    r;
    int unsigned pick;
    int unsigned sel;
    int unsigned lim;
    pick = $urandom_range(99);
    lim  = (top_reg == 16'hFFFF) ? 32'hFFFF : 32'(top_reg) + 32'd1;
    if (!gates_on && pick < 25) r.req = tpcpwm_pkg::REQ_ENABLE;
    else if (pick < 80) r.req = tpcpwm_pkg::REQ_TICK;
    else if (pick < 85) r.req = tpcpwm_pkg::REQ_RAW;
    else if (pick < 90) r.req = tpcpwm_pkg::REQ_PERMILLE;
    else if (pick < 94) r.req = tpcpwm_pkg::REQ_ENABLE;
    else if (pick < 97) r.req = tpcpwm_pkg::REQ_DISABLE;
    else r.req = 3'($urandom_range(32'(REQ_LAST_UNUSED), 32'(REQ_FIRST_UNUSED)));
    for (int i = 0; i < 3; i++) begin
      sel = $urandom_range(99);
      if (r.req == tpcpwm_pkg::REQ_PERMILLE) begin
        if (sel < 70) r.duty[i] = 16'($urandom_range(32'(tpcpwm_pkg::PERMILLE_FULL), 0));
        else if (sel < 85) r.duty[i] = sel[0] ? 16'(tpcpwm_pkg::PERMILLE_FULL) : '0;
        else r.duty[i] = 16'($urandom);
      end else begin
        if (sel < 60) r.duty[i] = 16'($urandom_range(lim, 0));
        else if (sel < 67) r.duty[i] = '0;
        else if (sel < 74) r.duty[i] = top_reg;
        else if (sel < 80) r.duty[i] = 16'(lim);
        else r.duty[i] = 16'($urandom);
      end
    end
    return r;
  endfunction

  task automatic random_config();
    logic [tpcpwm_pkg::CNT_W-1:0]  top;
    logic [tpcpwm_pkg::DEAD_W-1:0] dead;
    logic [tpcpwm_pkg::CNT_W-1:0]  trig;
    int unsigned                   p;
    p = $urandom_range(99);
    if (p < 60) top = 16'($urandom_range(40, 1));
    else if (p < 80) top = 16'($urandom_range(300, 41));
    else if (p < 90) top = 16'($urandom_range(2, 1));
    else if (p < 95) top = 16'd65534;
    else top = 16'($urandom_range(65534, 1000));
    p = $urandom_range(99);
    if (p < 60) dead = 7'($urandom_range(5, 0));
    else if (p < 85) dead = 7'($urandom_range(30, 6));
    else dead = 7'd127;
    p = $urandom_range(99);
    if (p < 70) trig = 16'($urandom_range(32'(top) + 32'd1, 0));
    else if (p < 80) trig = '0;
    else if (p < 90) trig = 16'hFFFF;
    else trig = 16'($urandom);
    write_config(top, dead, trig);
  endtask

  task automatic test_directed();
    write_config(16'd7, 7'd2, 16'd4);
    send_req(tpcpwm_pkg::REQ_ENABLE, '0, '0, '0);
    // Phase A never high, phase C compare above top so always high.
    send_req(tpcpwm_pkg::REQ_RAW, 16'd0, 16'd3, 16'd8);
    send_ticks(9);
    send_req(tpcpwm_pkg::REQ_PERMILLE, 16'd0, 16'd500, 16'hFFFF);
    send_ticks(9);
    send_req(tpcpwm_pkg::REQ_DISABLE, '0, '0, '0);
    send_ticks(1);
    send_req(REQ_FIRST_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_req(REQ_LAST_UNUSED, 16'h5555, 16'hAAAA, 16'h0000);
    send_req(tpcpwm_pkg::REQ_ENABLE, '0, '0, '0);
    send_req(tpcpwm_pkg::REQ_RAW, 16'hFFFF, 16'h0000, 16'h5555);
    send_req(tpcpwm_pkg::REQ_PERMILLE, 16'd1000, 16'd1001, 16'hAAAA);
  endtask

  // A top of zero holds the counter at zero with an update on every tick.
  task automatic test_top_zero();
    write_config(16'd0, 7'd0, 16'd0);
    send_ticks(3);
    send_req(tpcpwm_pkg::REQ_PERMILLE, 16'd1000, 16'd500, 16'd0);
    send_ticks(3);
  endtask

  // Lower the top while the counter sits above it, once counting up and
  // once counting down.
  task automatic test_top_shrink();
    int guard;
    write_config(16'd6, 7'd1, 16'd3);
    send_req(tpcpwm_pkg::REQ_RAW, 16'd2, 16'd4, 16'd7);
    guard = 0;
    do begin
      send_ticks(1);
      wait_results();
      guard++;
    end while (!(!pwm_down && pwm_cnt == 5) && guard < 40);
    write_config(16'd2, 7'd1, 16'd3);
    send_ticks(6);
    write_config(16'd6, 7'd1, 16'd3);
    guard = 0;
    do begin
      send_ticks(1);
      wait_results();
      guard++;
    end while (!(pwm_down && pwm_cnt == 5) && guard < 40);
    write_config(16'd3, 7'd1, 16'd3);
    send_ticks(6);
  endtask

  // Widest tops: the permille scale saturates at full duty.
  task automatic test_wide_top();
    write_config(16'hFFFF, 7'd127, 16'hFFFF);
    send_req(tpcpwm_pkg::REQ_PERMILLE, 16'd1000, 16'd999, 16'd1);
    send_ticks(4);
    write_config(16'd65534, 7'd0, 16'd65534);
    send_req(tpcpwm_pkg::REQ_PERMILLE, 16'd1000, 16'd1, 16'd500);
    send_ticks(4);
  endtask

  // A running dead-time count keeps going after the register is lowered.
  task automatic test_dead_change();
    write_config(16'd4, 7'd127, 16'd0);
    send_req(tpcpwm_pkg::REQ_RAW, 16'd2, 16'd3, 16'd1);
    send_ticks(12);
    write_config(16'd4, 7'd0, 16'd2);
    send_ticks(12);
  endtask

  task automatic test_random(int n, int src_pct, int snk_pct);
    int sent;
    int chunk;
    pwm_req_t r;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < n) begin
      random_config();
      chunk = int'($urandom_range(160, 60));
      if (chunk > n - sent) chunk = n - sent;
      repeat (chunk) begin
        r = rand_req();
        send_req(r.req, r.duty[0], r.duty[1], r.duty[2]);
      end
      sent += chunk;
    end
  endtask

  // Hold the result side long enough for the block to stall its input, then
  // pause the sender until everything outstanding has come back.
  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_config(16'd9, 7'd2, 16'd5);
    send_req(tpcpwm_pkg::REQ_ENABLE, '0, '0, '0);
    stall_cycles = 200;
    send_ticks(40);
    wait_results();
    send_ticks(20);
  endtask

  initial begin
    int guard;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= tpcpwm_pkg::REQ_TICK;
    in_ch.duty_a   <= '0;
    in_ch.duty_b   <= '0;
    in_ch.duty_c   <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= tpcpwm_pkg::CFG_PERIOD_TOP;
    cfg_ch.data    <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_top_zero();
    test_top_shrink();
    test_wide_top();
    test_dead_change();
    test_random(470, 23, 60);
    test_random(470, 60, 23);
    test_backpressure();
    test_random(450, 0, 0);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (gate_expect_q.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    if (gate_expect_q.size() != 0) begin
      $error("%0d expected results never arrived", gate_expect_q.size());
      n_errors += gate_expect_q.size();
    end
    repeat (8) @(posedge clk);

    $display("tb_top: %0d requests, %0d results checked, %0d update events, %0d reg writes",
             n_items, n_results, n_updates, n_reg_writes);
    $display("tb_top: directed corners, random duty traffic under three idle mixes, stall");
    if (n_errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// File: three_phase_center_pwm_top.f
src/tpcpwm_pkg.sv
src/tpcpwm_if.sv
src/three_phase_center_pwm_top.sv
test/tb_top.sv
